// File: design/midpoint_line_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint line rasterizer.
// Each macro checks a property on clk_i with reset rst_ni held low disabling it.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTERIZER_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared widths, command codes and structs of the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

  // Coordinate width of every endpoint and pixel.
  localparam int unsigned COORD_BITS = 11;
  // Signed decision term: covers -2*major .. 2*minor with margin.
  localparam int unsigned ERR_BITS = COORD_BITS + 3;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

  // Command codes carried on the input tuser.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // One command item as held in the input register.
  typedef struct packed {
    logic                  cmd;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } mlr_cmd_t;

  // One pixel result.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  pixel_valid;
    logic                  last_pixel;
  } mlr_pixel_t;

  // Status of the line walker.
  typedef struct packed {
    logic line_active;
  } mlr_status_t;

endpackage

// File: design/mlr_core.sv
// ----------------------------------------------------------------------------
// mlr_core
// Line state and step logic: setup on a start item, one major-axis
// step per step item, with the pixel result formed combinationally.
// ----------------------------------------------------------------------------
module mlr_core
  import mlr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,  // the item in cmd_i is consumed this cycle
  input  mlr_cmd_t    cmd_i,
  output mlr_pixel_t  pixel_o,
  output mlr_status_t status_o
);

  logic [COORD_BITS-1:0]      cur_x_q, cur_x_d;
  logic [COORD_BITS-1:0]      cur_y_q, cur_y_d;
  logic signed [ERR_BITS-1:0] err_q, err_d;
  logic [COORD_BITS-1:0]      steps_q, steps_d;
  logic [COORD_BITS-1:0]      major_q, major_d;
  logic [COORD_BITS-1:0]      minor_q, minor_d;
  logic                       x_dec_q, x_dec_d;
  logic                       y_dec_q, y_dec_d;
  logic                       y_major_q, y_major_d;
  logic                       active_q, active_d;

  // Setup terms of a new line.
  logic                  s_x_dec, s_y_dec, s_y_major;
  logic [COORD_BITS-1:0] s_dx, s_dy, s_major, s_minor;
  logic [ERR_BITS-1:0]   s_err;

  // Step terms of the line in progress.
  logic                  minor_moves;
  logic [ERR_BITS-1:0]   two_major, two_minor, step_err;
  logic [COORD_BITS-1:0] x_moved, y_moved;

  // Absolute deltas, directions and the major axis of the new line.
  always_comb begin
    s_x_dec   = cmd_i.end_x < cmd_i.start_x;
    s_y_dec   = cmd_i.end_y < cmd_i.start_y;
    s_dx      = s_x_dec ? cmd_i.start_x - cmd_i.end_x : cmd_i.end_x - cmd_i.start_x;
    s_dy      = s_y_dec ? cmd_i.start_y - cmd_i.end_y : cmd_i.end_y - cmd_i.start_y;
    s_y_major = s_dy > s_dx;
    s_major   = s_y_major ? s_dy : s_dx;
    s_minor   = s_y_major ? s_dx : s_dy;
    s_err     = {2'b00, s_minor, 1'b0} - {3'b000, s_major};
  end

  // Error update and unit moves along both axes.
  always_comb begin
    minor_moves = err_q > $signed({ERR_BITS{1'b0}});
    two_major   = {2'b00, major_q, 1'b0};
    two_minor   = {2'b00, minor_q, 1'b0};
    step_err    = err_q - (minor_moves ? two_major : {ERR_BITS{1'b0}}) + two_minor;
    x_moved     = x_dec_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
    y_moved     = y_dec_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
  end

  // Next state and pixel result.
  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    err_d     = err_q;
    steps_d   = steps_q;
    major_d   = major_q;
    minor_d   = minor_q;
    x_dec_d   = x_dec_q;
    y_dec_d   = y_dec_q;
    y_major_d = y_major_q;
    active_d  = active_q;
    pixel_o   = '0;

    case (cmd_i.cmd)
      CMD_START: begin
        cur_x_d   = cmd_i.start_x;
        cur_y_d   = cmd_i.start_y;
        err_d     = $signed(s_err);
        steps_d   = s_major;
        major_d   = s_major;
        minor_d   = s_minor;
        x_dec_d   = s_x_dec;
        y_dec_d   = s_y_dec;
        y_major_d = s_y_major;
        active_d  = s_major != '0;
        pixel_o.pixel_x     = cmd_i.start_x;
        pixel_o.pixel_y     = cmd_i.start_y;
        pixel_o.pixel_valid = 1'b1;
        pixel_o.last_pixel  = s_major == '0;
      end
      CMD_STEP: begin
        if (active_q) begin
          err_d    = $signed(step_err);
          steps_d  = steps_q - COORD_BITS'(1);
          active_d = steps_q != COORD_BITS'(1);
          if (y_major_q) begin
            cur_y_d = y_moved;
            if (minor_moves) begin
              cur_x_d = x_moved;
            end
          end else begin
            cur_x_d = x_moved;
            if (minor_moves) begin
              cur_y_d = y_moved;
            end
          end
          pixel_o.pixel_x     = cur_x_d;
          pixel_o.pixel_y     = cur_y_d;
          pixel_o.pixel_valid = 1'b1;
          pixel_o.last_pixel  = !active_d;
        end
      end
      default: begin
        pixel_o = '0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (advance_i) begin
      active_q <= active_d;
    end
  end

  // Line geometry, meaningful only while a line is active.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      err_q     <= err_d;
      steps_q   <= steps_d;
      major_q   <= major_d;
      minor_q   <= minor_d;
      x_dec_q   <= x_dec_d;
      y_dec_q   <= y_dec_d;
      y_major_q <= y_major_d;
    end
  end

  assign status_o.line_active = active_q;

endmodule

// File: design/midpoint_line_rasterizer.sv
// The pixel of an accepted item passes through the input register and then the
// output register. Throughput: one item per cycle while m_axis_tready holds, set
// by the combinational line step in mlr_core.
// The output register and the input register let a new item enter while a
// finished pixel waits. Reset is asynchronous, active low; it empties both
// registers and leaves no line active, so a step item then yields pixel_valid 0.
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Midpoint line rasterizer for all octants: start items load two endpoints,
// step items walk the line one pixel per item.
// ----------------------------------------------------------------------------
`include "midpoint_line_rasterizer_macros.svh"

module midpoint_line_rasterizer
  import mlr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input stream.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: start_x, start_y, end_x, end_y, zero pad (lowest bit first).
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // tuser: cmd.
  input  logic                     s_axis_tuser,
  // Output stream.
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // tdata: pixel_x, pixel_y, zero pad (lowest bit first).
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  // tuser: pixel_valid.
  output logic                     m_axis_tuser,
  // tlast: last_pixel.
  output logic                     m_axis_tlast
);

  logic        in_valid_q;
  mlr_cmd_t    in_cmd_q, in_cmd_d;
  logic        out_valid_q;
  mlr_pixel_t  out_pix_q;
  mlr_pixel_t  core_pix;
  mlr_status_t core_status;
  logic        advance;
  logic        in_take;

  // The held item moves on whenever the output register is free or being read.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Unpack the input stream.
  always_comb begin
    in_cmd_d.cmd     = s_axis_tuser;
    in_cmd_d.start_x = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    in_cmd_d.start_y = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    in_cmd_d.end_x   = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    in_cmd_d.end_y   = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q <= in_cmd_d;
    end
  end

  // Line state and step logic.
  mlr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cmd_i     (in_cmd_q),
    .pixel_o   (core_pix),
    .status_o  (core_status)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pix_q <= core_pix;
    end
  end

  // Pack the output stream.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_BITS - 2 * COORD_BITS){1'b0}},
                          out_pix_q.pixel_y, out_pix_q.pixel_x};
  assign m_axis_tuser  = out_pix_q.pixel_valid;
  assign m_axis_tlast  = out_pix_q.last_pixel;

  // Checks on the line walker and the pipeline.
  `MLR_ASSERT_NEXT(a_last_ends_line, advance && core_pix.last_pixel,
    !core_status.line_active, "line still active after its last pixel")
  `MLR_ASSERT_NEXT(a_idle_step_invalid,
    advance && (in_cmd_q.cmd == CMD_STEP) && !core_status.line_active,
    out_valid_q && !out_pix_q.pixel_valid, "step without a line gave a pixel")
  `MLR_ASSERT_SAME(a_last_is_pixel, m_axis_tvalid && m_axis_tlast,
    m_axis_tuser, "last flag on an empty result")
  `MLR_ASSERT_SAME(a_empty_input_ready, !in_valid_q, s_axis_tready,
    "input stalled while its register is empty")

endmodule
